### sv/bpf_pkg.sv
// Shared types and constants for the Bezier path flattener.
// No dependencies; used by every other file of the block.
`default_nettype none

package bpf_pkg;

	typedef enum logic [1:0] {
		CMD_MOVE  = 2'd0,
		CMD_LINE  = 2'd1,
		CMD_QUAD  = 2'd2,
		CMD_CUBIC = 2'd3
	} cmd_t;

	localparam int COORD_W = 16;   // input coordinates, font units
	localparam int FRAC_W  = 8;    // fraction bits of a vertex
	localparam int VERT_W  = 24;   // output vertex coordinate
	localparam int SEG_W   = 7;    // curve_segments register
	localparam int SQ_W    = 13;   // a*a, b*b, a*b, n*n (<= 4096)
	localparam int COEF_W  = 19;   // Bernstein weight, <= n^3 <= 2^18
	localparam int DEN_W   = 19;   // n^2 or n^3
	localparam int PROD_W  = 35;   // weight * coordinate, and their sum
	localparam int MAG_W   = 34;   // magnitude of the weighted sum
	localparam int NUM_W   = 43;   // 2*|sum|*256 + den
	localparam int QUO_W   = 24;   // quotient bits
	localparam int DIV_W   = 20;   // divider remainder, < 2*den
	localparam int CNT_W   = 5;    // divider step counter
	localparam int TERM_W  = 3;    // term counter, counts 0..5

	localparam logic [SEG_W-1:0] MAX_SEGMENTS = 7'd64;
	localparam logic [SEG_W-1:0] SEG_RESET    = 7'd10;

	// Commands from the sequencer to the arithmetic.
	typedef struct packed {
		logic             load_item;   // capture points of an accepted item
		logic             cur_upd;     // current point takes the end point
		logic             coef1;       // squares and products of a, b, n
		logic             coef2;       // four weights and denominator
		logic             mul_en;      // weight * point for the selected term
		logic             acc_en;      // add previous product to the sum
		logic [1:0]       term;        // term select: p0, c1, c2, end
		logic             prep;        // build dividend, load divider
		logic             div_step;    // one restoring divide step
		logic             load_direct; // vertex = end point
		logic             load_quot;   // vertex = rounded quotient
		logic             is_quad;
		logic [SEG_W-1:0] n;
		logic [SEG_W-1:0] i;
	} dp_cmd_t;

endpackage

`default_nettype wire

### sv/bpf_item_if.sv
// Input channel of the path flattener: one path instruction per transaction.
// Depends on bpf_pkg for field widths.
`default_nettype none

interface bpf_item_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          cmd;
	logic signed [bpf_pkg::COORD_W-1:0]  end_x;
	logic signed [bpf_pkg::COORD_W-1:0]  end_y;
	logic signed [bpf_pkg::COORD_W-1:0]  ctrl1_x;
	logic signed [bpf_pkg::COORD_W-1:0]  ctrl1_y;
	logic signed [bpf_pkg::COORD_W-1:0]  ctrl2_x;
	logic signed [bpf_pkg::COORD_W-1:0]  ctrl2_y;
	logic                                last_of_shape;

	modport source (output valid, cmd, end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
		last_of_shape, input ready);
	modport sink (input valid, cmd, end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
		last_of_shape, output ready);
endinterface

`default_nettype wire

### sv/bpf_vert_if.sv
// Output channel of the path flattener: one vertex per transaction.
// Depends on bpf_pkg for field widths.
`default_nettype none

interface bpf_vert_if;
	logic                               valid;
	logic                               ready;
	logic signed [bpf_pkg::VERT_W-1:0]  vert_x;
	logic signed [bpf_pkg::VERT_W-1:0]  vert_y;
	logic                               contour_start;
	logic                               last;

	modport source (output valid, vert_x, vert_y, contour_start, last, input ready);
	modport sink (input valid, vert_x, vert_y, contour_start, last, output ready);
endinterface

`default_nettype wire

### sv/bpf_datapath.sv
// Arithmetic of the path flattener: point registers, Bernstein weights,
// shared multiply-accumulate and a radix-2 rounding divider per axis. Uses bpf_pkg.
`default_nettype none

module bpf_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bpf_pkg::dp_cmd_t                   cmd,
	input  logic signed [bpf_pkg::COORD_W-1:0] end_x,
	input  logic signed [bpf_pkg::COORD_W-1:0] end_y,
	input  logic signed [bpf_pkg::COORD_W-1:0] ctrl1_x,
	input  logic signed [bpf_pkg::COORD_W-1:0] ctrl1_y,
	input  logic signed [bpf_pkg::COORD_W-1:0] ctrl2_x,
	input  logic signed [bpf_pkg::COORD_W-1:0] ctrl2_y,
	output logic signed [bpf_pkg::VERT_W-1:0]  vert_x,
	output logic signed [bpf_pkg::VERT_W-1:0]  vert_y
);
	import bpf_pkg::*;

	logic signed [COORD_W-1:0] end_w   [2];
	logic signed [COORD_W-1:0] ctrl1_w [2];
	logic signed [COORD_W-1:0] ctrl2_w [2];

	logic signed [COORD_W-1:0] cur_q  [2];
	logic signed [COORD_W-1:0] pt_q   [2][4];
	logic signed [PROD_W-1:0]  prod_q [2];
	logic signed [PROD_W-1:0]  acc_q  [2];
	logic                      neg_q  [2];
	logic [DIV_W-1:0]          rem_q  [2];
	logic [QUO_W-1:0]          nq_q   [2];
	logic signed [VERT_W-1:0]  vert_q [2];

	logic [SQ_W-1:0]   a2_q, b2_q, ab_q, nn_q;
	logic [COEF_W-1:0] k_q [4];
	logic [COEF_W-1:0] k_w [4];
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  den_w;
	logic [SEG_W-1:0]  a_w;
	logic [COEF_W-1:0] a19, b19, a2_19, b2_19, ab19;

	assign end_w   = '{end_x, end_y};
	assign ctrl1_w = '{ctrl1_x, ctrl1_y};
	assign ctrl2_w = '{ctrl2_x, ctrl2_y};

	// sample t = i/n: a = n - i, b = i
	assign a_w   = cmd.n - cmd.i;
	assign a19   = COEF_W'(a_w);
	assign b19   = COEF_W'(cmd.i);
	assign a2_19 = COEF_W'(a2_q);
	assign b2_19 = COEF_W'(b2_q);
	assign ab19  = COEF_W'(ab_q);

	always_comb begin
		if (cmd.is_quad) begin
			k_w[0] = a2_19;
			k_w[1] = ab19 + ab19;
			k_w[2] = '0;
			k_w[3] = b2_19;
			den_w  = DEN_W'(nn_q);
		end else begin
			k_w[0] = a2_19 * a19;
			k_w[1] = COEF_W'(3) * a2_19 * b19;
			k_w[2] = COEF_W'(3) * b2_19 * a19;
			k_w[3] = b2_19 * b19;
			den_w  = DEN_W'(nn_q) * DEN_W'(cmd.n);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.coef1) begin
			a2_q <= SQ_W'(a_w) * SQ_W'(a_w);
			b2_q <= SQ_W'(cmd.i) * SQ_W'(cmd.i);
			ab_q <= SQ_W'(a_w) * SQ_W'(cmd.i);
			nn_q <= SQ_W'(cmd.n) * SQ_W'(cmd.n);
		end
		if (cmd.coef2) begin
			k_q   <= k_w;
			den_q <= den_w;
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_axis
		logic signed [PROD_W-1:0] mag_w;
		logic [NUM_W-1:0]         num_w;
		logic [DIV_W:0]           shifted_w;
		logic [DIV_W:0]           diff_w;

		always_comb begin
			mag_w     = acc_q[g][PROD_W-1] ? -acc_q[g] : acc_q[g];
			// 2*|sum|*256 + den: rounds half away from zero after / (2*den)
			num_w     = {mag_w[MAG_W-1:0], (FRAC_W + 1)'(0)} + NUM_W'(den_q);
			shifted_w = {rem_q[g], nq_q[g][QUO_W-1]};
			diff_w    = shifted_w - {1'b0, den_q, 1'b0};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cur_q[g] <= '0;
			end else if (cmd.cur_upd) begin
				cur_q[g] <= end_w[g];
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.load_item) begin
				pt_q[g][0] <= cur_q[g];
				pt_q[g][1] <= ctrl1_w[g];
				pt_q[g][2] <= ctrl2_w[g];
				pt_q[g][3] <= end_w[g];
			end
			if (cmd.mul_en) begin
				prod_q[g] <= $signed({1'b0, k_q[cmd.term]}) * pt_q[g][cmd.term];
			end
			if (cmd.coef2) begin
				acc_q[g] <= '0;
			end else if (cmd.acc_en) begin
				acc_q[g] <= acc_q[g] + prod_q[g];
			end
			if (cmd.prep) begin
				neg_q[g] <= acc_q[g][PROD_W-1];
				rem_q[g] <= DIV_W'(num_w[NUM_W-1:QUO_W]);
				nq_q[g]  <= num_w[QUO_W-1:0];
			end else if (cmd.div_step) begin
				if (!diff_w[DIV_W]) begin
					rem_q[g] <= diff_w[DIV_W-1:0];
					nq_q[g]  <= {nq_q[g][QUO_W-2:0], 1'b1};
				end else begin
					rem_q[g] <= shifted_w[DIV_W-1:0];
					nq_q[g]  <= {nq_q[g][QUO_W-2:0], 1'b0};
				end
			end
			if (cmd.load_direct) begin
				vert_q[g] <= {pt_q[g][3], FRAC_W'(0)};
			end else if (cmd.load_quot) begin
				vert_q[g] <= neg_q[g] ? -$signed(nq_q[g]) : $signed(nq_q[g]);
			end
		end
	end

	assign vert_x = vert_q[0];
	assign vert_y = vert_q[1];

endmodule

`default_nettype wire

### sv/bpf_ctrl.sv
// Sequencer of the path flattener: handshakes, segment register, contour
// state and per-vertex step control of bpf_datapath. Uses bpf_pkg.
`default_nettype none

module bpf_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      in_cmd,
	input  logic                            in_last_of_shape,
	input  logic                            cfg_we,
	input  logic [bpf_pkg::SEG_W-1:0]       cfg_wdata,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            out_contour_start,
	output logic                            out_last,
	output bpf_pkg::dp_cmd_t                dp_cmd
);
	import bpf_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DIRECT = 8'b0000_0010,
		ST_COEF1  = 8'b0000_0100,
		ST_COEF2  = 8'b0000_1000,
		ST_TERM   = 8'b0001_0000,
		ST_PREP   = 8'b0010_0000,
		ST_DIVIDE = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [SEG_W-1:0]  segs_q, n_sat, n_q, i_q;
	logic [TERM_W-1:0] term_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              open_q, start_q, is_quad_q;
	logic              out_valid_q, out_start_q, out_last_q;
	logic              out_free, accept, take_direct, take_curve;
	cmd_t              cmd_w;

	assign cmd_w    = cmd_t'(in_cmd);
	assign n_sat    = (segs_q > MAX_SEGMENTS) ? MAX_SEGMENTS : segs_q;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Draws outside an open contour, and zero-segment curves, produce nothing.
	always_comb begin
		take_direct = 1'b0;
		take_curve  = 1'b0;
		if (cmd_w == CMD_MOVE) begin
			take_direct = 1'b1;
		end else if (open_q) begin
			if (cmd_w == CMD_LINE || n_sat == SEG_W'(1)) begin
				take_direct = 1'b1;
			end else if (n_sat != '0) begin
				take_curve = 1'b1;
			end
		end
	end

	always_comb begin
		state_d             = state_q;
		dp_cmd              = '0;
		dp_cmd.n            = n_q;
		dp_cmd.i            = i_q;
		dp_cmd.is_quad      = is_quad_q;
		dp_cmd.term         = term_q[1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					dp_cmd.load_item = 1'b1;
					dp_cmd.cur_upd   = take_direct || take_curve;
					if (take_direct) begin
						state_d = ST_DIRECT;
					end else if (take_curve) begin
						state_d = ST_COEF1;
					end
				end
			end
			ST_DIRECT: begin
				if (out_free) begin
					dp_cmd.load_direct = 1'b1;
					state_d            = ST_IDLE;
				end
			end
			ST_COEF1: begin
				dp_cmd.coef1 = 1'b1;
				state_d      = ST_COEF2;
			end
			ST_COEF2: begin
				dp_cmd.coef2 = 1'b1;
				state_d      = ST_TERM;
			end
			ST_TERM: begin
				// products for terms 0..3, each added to the sum in the following cycle
				dp_cmd.mul_en = !term_q[TERM_W-1];
				dp_cmd.acc_en = (term_q != '0);
				if (term_q[TERM_W-1]) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				dp_cmd.prep = 1'b1;
				state_d     = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				dp_cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					dp_cmd.load_quot = 1'b1;
					state_d          = (i_q == n_q) ? ST_IDLE : ST_COEF1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			segs_q      <= SEG_RESET;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
			n_q         <= '0;
			i_q         <= '0;
			term_q      <= '0;
			cnt_q       <= '0;
			start_q     <= 1'b0;
			is_quad_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				segs_q <= cfg_wdata;
			end
			if (accept) begin
				open_q    <= in_last_of_shape ? 1'b0 : (open_q || cmd_w == CMD_MOVE);
				n_q       <= n_sat;
				i_q       <= SEG_W'(1);
				start_q   <= (cmd_w == CMD_MOVE);
				is_quad_q <= (cmd_w == CMD_QUAD);
			end else if (dp_cmd.load_quot) begin
				i_q <= i_q + SEG_W'(1);
			end
			if (dp_cmd.coef2) begin
				term_q <= '0;
			end else if (state_q == ST_TERM) begin
				term_q <= term_q + TERM_W'(1);
			end
			if (dp_cmd.prep) begin
				cnt_q <= '0;
			end else if (dp_cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (dp_cmd.load_direct || dp_cmd.load_quot) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load_direct) begin
			out_start_q <= start_q;
			out_last_q  <= 1'b1;
		end else if (dp_cmd.load_quot) begin
			out_start_q <= 1'b0;
			out_last_q  <= (i_q == n_q);
		end
	end

	assign out_valid         = out_valid_q;
	assign out_contour_start = out_start_q;
	assign out_last          = out_last_q;

endmodule

`default_nettype wire

### sv/bezier_path_flattener.sv
// Top level of the Bezier path flattener: joins bpf_ctrl and bpf_datapath
// to the bpf_item_if and bpf_vert_if channels. Uses bpf_pkg.
`default_nettype none

// Flattens glyph path instructions (move, line, quadratic, cubic) into
// vertices in signed 16.8 fixed point. A move, or a line in an open contour,
// takes one transaction in and gives one vertex, its end point, through the
// output register. A curve with n segments gives n vertices at t = i/n, each
// formed in turn by ST_COEF1 and ST_COEF2 for the Bernstein weights, ST_TERM
// for the shared multiply-accumulate over the four terms, ST_PREP to form the
// dividend, ST_DIVIDE for the radix-2 restoring divider that rounds the
// weighted sum by n^2 or n^3, and ST_EMIT to load the output register. The
// next instruction is accepted once the last vertex of a curve sits in the
// output register. curve_segments resets to 10 and saturates at 64; write it
// only while the block is idle.
module bezier_path_flattener (
	input  logic                        clk,
	input  logic                        arst_n,
	bpf_item_if.sink                    instr,
	bpf_vert_if.source                  vertex,
	input  logic                        cfg_we,
	input  logic [bpf_pkg::SEG_W-1:0]   cfg_wdata
);
	import bpf_pkg::*;

	dp_cmd_t dp_cmd;

	bpf_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (instr.valid),
		.in_ready          (instr.ready),
		.in_cmd            (instr.cmd),
		.in_last_of_shape  (instr.last_of_shape),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.out_valid         (vertex.valid),
		.out_ready         (vertex.ready),
		.out_contour_start (vertex.contour_start),
		.out_last          (vertex.last),
		.dp_cmd            (dp_cmd)
	);

	bpf_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (dp_cmd),
		.end_x   (instr.end_x),
		.end_y   (instr.end_y),
		.ctrl1_x (instr.ctrl1_x),
		.ctrl1_y (instr.ctrl1_y),
		.ctrl2_x (instr.ctrl2_x),
		.ctrl2_y (instr.ctrl2_y),
		.vert_x  (vertex.vert_x),
		.vert_y  (vertex.vert_y)
	);

`ifndef SYNTH
	// sequencer phases never overlap
	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dp_cmd.coef1, dp_cmd.coef2, dp_cmd.prep, dp_cmd.div_step,
			dp_cmd.load_direct, dp_cmd.load_quot}))
		else $error("overlapping datapath phases");

	// no new instruction while a division is running
	a_no_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.div_step |-> !instr.ready)
		else $error("input ready during divide");

	// a curve sample is a valid vertex that never starts a contour
	a_curve_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load_quot |=> vertex.valid && !vertex.contour_start)
		else $error("bad curve vertex");
`endif

endmodule

`default_nettype wire

### test/bezier_path_flattener_tb.sv
// Self-checking testbench for bezier_path_flattener: drives path instructions,
// predicts every vertex in SystemVerilog and checks the vertex stream.
// Depends on bpf_pkg, bpf_item_if, bpf_vert_if and the RTL of the block.
`default_nettype none

module bezier_path_flattener_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bpf_pkg::*;

	localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 100;   // settle time after the last vertex
	localparam int MAX_PRINTS   = 30;

	typedef struct {
		cmd_t                      cmd;
		logic signed [COORD_W-1:0] ex, ey, c1x, c1y, c2x, c2y;
		logic                      close;
	} instr_t;

	typedef struct {
		logic signed [VERT_W-1:0] x, y;
		logic                     cs, lst;
	} vert_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [SEG_W-1:0] cfg_wdata;

	bpf_item_if instr_bus ();
	bpf_vert_if vert_bus ();

	bezier_path_flattener u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.instr     (instr_bus),
		.vertex    (vert_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// predictor state
	logic signed [COORD_W-1:0] pen_x, pen_y;
	logic                      contour_on;
	logic [SEG_W-1:0]          seg_reg;
	vert_t                     pending_verts[$];

	int  err_count;
	int  instr_count;
	int  drawn_count;
	int  vert_count;
	int  seg_writes;
	bit  idle_en;
	bit  stall_en;
	bit  hold_req;

	task automatic report_mismatch(string what);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("mismatch @%0t: %s", $time, what);
	endtask

	function automatic longint div_near(longint num, longint den);
		if (num >= 0)
			return (2 * num + den) / (2 * den);
		return -((2 * (-num) + den) / (2 * den));
	endfunction

	function automatic void push_vert(longint x, longint y, logic cs);
		vert_t v;
		v.x   = x[VERT_W-1:0];
		v.y   = y[VERT_W-1:0];
		v.cs  = cs;
		v.lst = 1'b0;
		pending_verts.insert(pending_verts.size(), v);
	endfunction

	// Expected vertices of one instruction, appended to pending_verts.
	function automatic void flatten_instr(instr_t it);
		longint n, a, b, nx, ny, den;
		longint p0x, p0y, c1x, c1y, c2x, c2y, ex, ey;
		int cnt;
		cnt = 0;
		ex  = it.ex;
		ey  = it.ey;
		c1x = it.c1x;
		c1y = it.c1y;
		c2x = it.c2x;
		c2y = it.c2y;
		n   = (seg_reg > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_reg;
		if (it.cmd == CMD_MOVE) begin
			contour_on = 1'b1;
			push_vert(ex * 256, ey * 256, 1'b1);
			cnt   = 1;
			pen_x = it.ex;
			pen_y = it.ey;
		end else if (contour_on) begin
			if (it.cmd == CMD_LINE || n == 1) begin
				push_vert(ex * 256, ey * 256, 1'b0);
				cnt   = 1;
				pen_x = it.ex;
				pen_y = it.ey;
			end else if (n > 1) begin
				p0x = pen_x;
				p0y = pen_y;
				for (longint i = 1; i <= n; i++) begin
					a = n - i;
					b = i;
					if (it.cmd == CMD_QUAD) begin
						nx  = a*a*p0x + 2*a*b*c1x + b*b*ex;
						ny  = a*a*p0y + 2*a*b*c1y + b*b*ey;
						den = n * n;
					end else begin
						nx  = a*a*a*p0x + 3*a*a*b*c1x + 3*a*b*b*c2x + b*b*b*ex;
						ny  = a*a*a*p0y + 3*a*a*b*c1y + 3*a*b*b*c2y + b*b*b*ey;
						den = n * n * n;
					end
					push_vert(div_near(nx * 256, den), div_near(ny * 256, den), 1'b0);
					cnt++;
				end
				pen_x = it.ex;
				pen_y = it.ey;
			end
		end
		if (cnt > 0)
			pending_verts[pending_verts.size()-1].lst = 1'b1;
		if (it.close)
			contour_on = 1'b0;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			3: return -16'sd1;
			4, 5: return COORD_W'($signed($urandom_range(0, 400)) - 200);
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic instr_t mk_instr(cmd_t c, logic signed [COORD_W-1:0] ex,
			logic signed [COORD_W-1:0] ey, logic close);
		instr_t it;
		it.cmd   = c;
		it.ex    = ex;
		it.ey    = ey;
		it.c1x   = rand_coord();
		it.c1y   = rand_coord();
		it.c2x   = rand_coord();
		it.c2y   = rand_coord();
		it.close = close;
		return it;
	endfunction

	// Offers one instruction and returns at the edge it is taken; valid stays high.
	task automatic send_instr(instr_t it);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			instr_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		instr_bus.valid         <= 1'b1;
		instr_bus.cmd           <= it.cmd;
		instr_bus.end_x         <= it.ex;
		instr_bus.end_y         <= it.ey;
		instr_bus.ctrl1_x       <= it.c1x;
		instr_bus.ctrl1_y       <= it.c1y;
		instr_bus.ctrl2_x       <= it.c2x;
		instr_bus.ctrl2_y       <= it.c2y;
		instr_bus.last_of_shape <= it.close;
		@(posedge clk);
		while (!instr_bus.ready)
			@(posedge clk);
		instr_count++;
		if (it.cmd == CMD_MOVE || contour_on)
			drawn_count++;
		flatten_instr(it);
	endtask

	task automatic wait_drained();
		instr_bus.valid <= 1'b0;
		while (pending_verts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_segments(logic [SEG_W-1:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		seg_reg = v;
		seg_writes++;
		cfg_we <= 1'b0;
	endtask

	// receiver: random stalls, and one long hold-off on request
	initial begin : vertex_receiver
		int burst;
		burst = 0;
		vert_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (burst > 0) begin
				burst--;
			end else if (hold_req) begin
				vert_bus.ready <= 1'b0;
				burst    = HOLD_CYCLES - 1;
				hold_req = 1'b0;
			end else if (stall_en && $urandom_range(0, 4) == 0) begin
				vert_bus.ready <= 1'b0;
				burst = $urandom_range(0, 3);
			end else begin
				vert_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : vertex_check
		vert_t want;
		if (arst_n && vert_bus.valid && vert_bus.ready) begin
			vert_count++;
			if (pending_verts.size() == 0) begin
				report_mismatch($sformatf("vertex %0d unexpected: x=%0d y=%0d",
					vert_count, vert_bus.vert_x, vert_bus.vert_y));
			end else begin
				want = pending_verts.pop_front();
				if (vert_bus.vert_x !== want.x)
					report_mismatch($sformatf("vertex %0d vert_x %0d, want %0d",
						vert_count, vert_bus.vert_x, want.x));
				if (vert_bus.vert_y !== want.y)
					report_mismatch($sformatf("vertex %0d vert_y %0d, want %0d",
						vert_count, vert_bus.vert_y, want.y));
				if (vert_bus.contour_start !== want.cs)
					report_mismatch($sformatf("vertex %0d contour_start %b, want %b",
						vert_count, vert_bus.contour_start, want.cs));
				if (vert_bus.last !== want.lst)
					report_mismatch($sformatf("vertex %0d last %b, want %b",
						vert_count, vert_bus.last, want.lst));
			end
		end
	end

	// draws with no open contour must produce nothing
	task automatic test_before_contour();
		send_instr(mk_instr(CMD_LINE, rand_coord(), rand_coord(), 1'b0));
		send_instr(mk_instr(CMD_QUAD, rand_coord(), rand_coord(), 1'b1));
		send_instr(mk_instr(CMD_CUBIC, rand_coord(), rand_coord(), 1'b0));
	endtask

	task automatic test_default_segments();
		send_instr(mk_instr(CMD_MOVE, -16'sd32768, 16'sd32767, 1'b0));
		send_instr(mk_instr(CMD_LINE, 16'sd32767, -16'sd32768, 1'b0));
		send_instr(mk_instr(CMD_QUAD, 16'sd0, 16'sd32767, 1'b0));
		send_instr(mk_instr(CMD_CUBIC, -16'sd32768, -16'sd1, 1'b1));
	endtask

	task automatic test_move_reopen();
		send_instr(mk_instr(CMD_MOVE, 16'sd100, -16'sd50, 1'b0));
		send_instr(mk_instr(CMD_LINE, rand_coord(), rand_coord(), 1'b0));
		send_instr(mk_instr(CMD_MOVE, rand_coord(), rand_coord(), 1'b0));
		send_instr(mk_instr(CMD_LINE, rand_coord(), rand_coord(), 1'b1));
		send_instr(mk_instr(CMD_LINE, rand_coord(), rand_coord(), 1'b0));
		// a move that also ends the shape still emits its point
		send_instr(mk_instr(CMD_MOVE, rand_coord(), rand_coord(), 1'b1));
		send_instr(mk_instr(CMD_QUAD, rand_coord(), rand_coord(), 1'b0));
	endtask

	task automatic test_segment_extremes();
		set_segments(7'd1);
		send_instr(mk_instr(CMD_MOVE, rand_coord(), rand_coord(), 1'b0));
		send_instr(mk_instr(CMD_CUBIC, rand_coord(), rand_coord(), 1'b1));
		set_segments(7'd0);
		send_instr(mk_instr(CMD_MOVE, rand_coord(), rand_coord(), 1'b0));
		send_instr(mk_instr(CMD_QUAD, rand_coord(), rand_coord(), 1'b0));
		send_instr(mk_instr(CMD_LINE, rand_coord(), rand_coord(), 1'b1));
		set_segments(MAX_SEGMENTS);
		send_instr(mk_instr(CMD_MOVE, -16'sd32768, -16'sd32768, 1'b0));
		send_instr(mk_instr(CMD_CUBIC, 16'sd32767, 16'sd32767, 1'b1));
		// above the maximum: saturates
		set_segments(7'd127);
		send_instr(mk_instr(CMD_MOVE, rand_coord(), rand_coord(), 1'b0));
		send_instr(mk_instr(CMD_QUAD, rand_coord(), rand_coord(), 1'b1));
		set_segments(7'd2);
		send_instr(mk_instr(CMD_MOVE, rand_coord(), rand_coord(), 1'b0));
		send_instr(mk_instr(CMD_CUBIC, rand_coord(), rand_coord(), 1'b1));
	endtask

	task automatic test_output_backpressure();
		set_segments(7'd3);
		hold_req = 1'b1;
		send_instr(mk_instr(CMD_MOVE, rand_coord(), rand_coord(), 1'b0));
		repeat (12)
			send_instr(mk_instr(CMD_LINE, rand_coord(), rand_coord(), 1'b0));
		send_instr(mk_instr(CMD_QUAD, rand_coord(), rand_coord(), 1'b1));
	endtask

	task automatic pick_segments();
		case ($urandom_range(0, 15))
			0:       set_segments(MAX_SEGMENTS);
			1:       set_segments(SEG_W'($urandom_range(65, 127)));
			2:       set_segments(7'd0);
			3:       set_segments(7'd1);
			4:       set_segments(SEG_W'($urandom_range(11, 20)));
			default: set_segments(SEG_W'($urandom_range(2, 10)));
		endcase
	endtask

	// one glyph: mostly a well-formed contour, sometimes noise
	task automatic send_glyph();
		int draws;
		instr_t it;
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				it = mk_instr(cmd_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
					1'($urandom));
				send_instr(it);
			end
		end else begin
			send_instr(mk_instr(CMD_MOVE, rand_coord(), rand_coord(), 1'b0));
			draws = $urandom_range(1, 6);
			for (int k = 0; k < draws; k++) begin
				case ($urandom_range(0, 9))
					0:          it = mk_instr(CMD_MOVE, rand_coord(), rand_coord(), 1'b0);
					1, 2, 3:    it = mk_instr(CMD_LINE, rand_coord(), rand_coord(), 1'b0);
					4, 5, 6:    it = mk_instr(CMD_QUAD, rand_coord(), rand_coord(), 1'b0);
					default:    it = mk_instr(CMD_CUBIC, rand_coord(), rand_coord(), 1'b0);
				endcase
				it.close = (k == draws - 1);
				send_instr(it);
			end
		end
	endtask

	task automatic test_random_glyphs(int target);
		int start;
		start = drawn_count;
		while (drawn_count - start < target) begin
			if ($urandom_range(0, 2) == 0)
				pick_segments();
			send_glyph();
		end
	endtask

	task automatic test_no_idle();
		set_segments(7'd4);
		idle_en  = 1'b0;
		stall_en = 1'b0;
		test_random_glyphs(20);
	endtask

	initial begin
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_wdata               = '0;
		instr_bus.valid         = 1'b0;
		instr_bus.cmd           = CMD_MOVE;
		instr_bus.end_x         = '0;
		instr_bus.end_y         = '0;
		instr_bus.ctrl1_x       = '0;
		instr_bus.ctrl1_y       = '0;
		instr_bus.ctrl2_x       = '0;
		instr_bus.ctrl2_y       = '0;
		instr_bus.last_of_shape = 1'b0;
		pen_x       = '0;
		pen_y       = '0;
		contour_on  = 1'b0;
		seg_reg     = SEG_RESET;
		err_count   = 0;
		instr_count = 0;
		drawn_count = 0;
		vert_count  = 0;
		seg_writes  = 0;
		idle_en     = 1'b1;
		stall_en    = 1'b1;
		hold_req    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_contour();
		test_default_segments();
		test_move_reopen();
		test_segment_extremes();
		test_output_backpressure();
		test_random_glyphs(120);
		test_no_idle();

		wait_drained();
		$display("%0d instructions sent (%0d drawn), %0d vertices checked",
			instr_count, drawn_count, vert_count);
		$display("%0d curve_segments writes, 0 to saturated, plus one long output hold-off",
			seg_writes);
		if (err_count == 0)
			$display("PASS bezier_path_flattener");
		else
			$display("FAIL bezier_path_flattener");
		$finish;
	end

	initial begin
		#(30_000_000);
		$display("timeout: %0d vertices still expected", pending_verts.size());
		$display("FAIL bezier_path_flattener");
		$finish;
	end

endmodule

`default_nettype wire
